// ===== src/tank_level_trend_estimator_assert.svh =====
// Assertion macros shared by the tank level trend estimator RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TANK_LEVEL_TREND_ESTIMATOR_ASSERT_SVH
`define TANK_LEVEL_TREND_ESTIMATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only out of reset
`define TLTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included
`define TLTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TLTE_ASSERT(lbl, prop, msg)
`define TLTE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/tlte_pkg.sv =====
package tlte_pkg;

  // Configuration port
  localparam int unsigned CfgAw = 3;
  localparam int unsigned CfgDw = 27;

  typedef enum logic [CfgAw-1:0] {
    CFG_INTERVAL  = 3'd0,
    CFG_MIN_RAW   = 3'd1,
    CFG_MAX_RAW   = 3'd2,
    CFG_ZERO_RAW  = 3'd3,
    CFG_GAIN      = 3'd4,
    CFG_RANGE     = 3'd5,
    CFG_MIN_SLOPE = 3'd6,
    CFG_AREA      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_WARMING = 2'd0,
    ST_OK      = 2'd1,
    ST_OPEN    = 2'd2,
    ST_OVER    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TR_UNKNOWN = 2'd0,
    TR_STEADY  = 2'd1,
    TR_FALLING = 2'd2,
    TR_RISING  = 2'd3
  } trend_e;

  typedef struct packed {
    logic [15:0] interval;
    logic [11:0] min_raw;
    logic [11:0] max_raw;
    logic [11:0] zero_raw;
    logic [23:0] gain;
    logic [15:0] range_mm;
    logic [19:0] min_slope;
    logic [26:0] area;
  } cfg_t;

  // Command from front to back; kind ST_OK is a healthy sample
  typedef struct packed {
    status_e     kind;
    logic [31:0] now;
    logic [15:0] level;
  } cmd_t;

  // Command queue depth, a power of two
  localparam int unsigned QDepth = 2;

  // Shared multiplier: multiplicand and multiplier widths
  localparam int unsigned PW = 152;
  localparam int unsigned MW = 64;

  typedef struct packed {
    logic          start;
    logic [PW-1:0] mcand;
    logic [MW-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [PW-1:0] product;
  } mul_rsp_t;

  // Sum and fit widths, sized for a window of up to 64 samples
  localparam int unsigned StW   = 38;
  localparam int unsigned SyW   = 22;
  localparam int unsigned StyW  = 54;
  localparam int unsigned SyyW  = 38;
  localparam int unsigned SttW  = 70;
  localparam int unsigned AW    = 80;
  localparam int unsigned BW    = 64;
  localparam int unsigned CW    = 48;
  localparam int unsigned B2W   = 128;
  localparam int unsigned NumW  = 96;
  localparam int unsigned DenW  = 112;

  localparam logic [MW-1:0] ScaleUm = 64'd1000000;
  localparam logic [6:0]    FlowMul = 7'd60;

  // Fit sequence: one shared multiply per step
  typedef enum logic [3:0] {
    OP_NSTT  = 4'd0,
    OP_STST  = 4'd1,
    OP_NSTY  = 4'd2,
    OP_STSY  = 4'd3,
    OP_NSYY  = 4'd4,
    OP_SYSY  = 4'd5,
    OP_FLR_B = 4'd6,
    OP_FLR_A = 4'd7,
    OP_BB    = 4'd8,
    OP_AC    = 4'd9,
    OP_LHS   = 4'd10,
    OP_RHS   = 4'd11,
    OP_FLOW  = 4'd12
  } mop_e;

endpackage

// ===== src/tlte_front.sv =====
module tlte_front #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlte_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      now_ms_i,
  input  logic [11:0]      raw_i,
  input  logic             full_i,
  output logic             push_o,
  output tlte_pkg::cmd_t   cmd_o
);

  localparam int unsigned MaskBits = (ADC_BITS < 12) ? ADC_BITS : 12;
  localparam logic [11:0] RawMask = 12'((64'd1 << MaskBits) - 64'd1);

  logic [31:0] last_q;
  logic [31:0] elapsed;
  logic        due;
  logic        accept;
  logic [11:0] raw_m;
  logic [11:0] diff;
  logic [35:0] scaled;
  logic [19:0] lvl_raw;
  logic [15:0] lvl;

  // Take a request whenever the queue has room
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Drop ticks that come before the interval has passed
  assign elapsed = now_ms_i - last_q;
  assign due     = elapsed >= {16'd0, cfg_i.interval};
  assign push_o  = accept && due;

  // Scale the count to millimetres and clamp
  assign raw_m   = raw_i & RawMask;
  assign diff    = raw_m - cfg_i.zero_raw;
  assign scaled  = 36'(diff) * 36'(cfg_i.gain);
  assign lvl_raw = scaled[35:16];

  always_comb begin
    if (raw_m <= cfg_i.zero_raw) begin
      lvl = '0;
    end else if (lvl_raw > {4'd0, cfg_i.range_mm}) begin
      lvl = cfg_i.range_mm;
    end else begin
      lvl = lvl_raw[15:0];
    end
  end

  // Classify against the healthy window
  always_comb begin
    cmd_o.now   = now_ms_i;
    cmd_o.level = lvl;
    if (raw_m < cfg_i.min_raw) begin
      cmd_o.kind = tlte_pkg::ST_OPEN;
    end else if (raw_m > cfg_i.max_raw) begin
      cmd_o.kind = tlte_pkg::ST_OVER;
    end else begin
      cmd_o.kind = tlte_pkg::ST_OK;
    end
  end

  // Hold the time of the last sample taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (push_o) begin
      last_q <= now_ms_i;
    end
  end

endmodule

// ===== src/tlte_fifo.sv =====
`include "tank_level_trend_estimator_assert.svh"

module tlte_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlte_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tlte_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (tlte_pkg::QDepth > 1) ? $clog2(tlte_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(tlte_pkg::QDepth + 1);

  tlte_pkg::cmd_t mem_q [tlte_pkg::QDepth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (32'(cnt_q) == tlte_pkg::QDepth);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `TLTE_ASSERT(a_no_overflow, push_i |-> !full_o, "request pushed into a full queue")
  `TLTE_ASSERT(a_no_underflow, pop_i |-> valid_o, "request popped from an empty queue")
  `TLTE_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || 32'(cnt_q) <= tlte_pkg::QDepth, "queue count out of range")

endmodule

// ===== src/tlte_mul.sv =====
module tlte_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlte_pkg::mul_req_t req_i,
  output tlte_pkg::mul_rsp_t rsp_o
);

  logic                    busy_q;
  logic [tlte_pkg::PW-1:0] acc_q;
  logic [tlte_pkg::PW-1:0] mc_q;
  logic [tlte_pkg::MW-1:0] mp_q;

  // Done once the multiplier has no set bits left
  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = busy_q && (mp_q == '0);
  assign rsp_o.product = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (rsp_o.done) begin
      busy_q <= 1'b0;
    end
  end

  // Shift-add, one multiplier bit a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      mc_q  <= req_i.mcand;
      mp_q  <= req_i.mplier;
    end else if (busy_q && (mp_q != '0)) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

endmodule

// ===== src/tlte_back.sv =====
`include "tank_level_trend_estimator_assert.svh"

module tlte_back #(
  parameter int unsigned WINDOW_SAMPLES    = 16,
  parameter int unsigned MIN_TREND_SAMPLES = 3,
  parameter int unsigned T_STAT_Q8         = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlte_pkg::cfg_t     cfg_i,
  input  logic               q_valid_i,
  input  tlte_pkg::cmd_t     cmd_i,
  output logic               q_pop_o,
  output tlte_pkg::mul_req_t mul_req_o,
  input  tlte_pkg::mul_rsp_t mul_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [1:0]         trend_o,
  output logic [15:0]        level_mm_o,
  output logic [31:0]        flow_ml_per_min_o
);

  localparam int unsigned HW   = $clog2(WINDOW_SAMPLES);
  localparam int unsigned CntW = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned MinN = (MIN_TREND_SAMPLES > 3) ? MIN_TREND_SAMPLES : 3;
  localparam logic [tlte_pkg::MW-1:0] TStat2 = 64'(T_STAT_Q8 * T_STAT_Q8);
  localparam logic [CntW:0] WinW = (CntW+1)'(WINDOW_SAMPLES);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RD     = 8'b0000_0010,
    S_MAC    = 8'b0000_0100,
    S_ADD    = 8'b0000_1000,
    S_MSTART = 8'b0001_0000,
    S_MWAIT  = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q;
  tlte_pkg::mop_e op_q;

  // Sample ring
  logic [31:0] ring_time [WINDOW_SAMPLES];
  logic [15:0] ring_level [WINDOW_SAMPLES];
  logic [31:0] rd_time_q;
  logic [15:0] rd_level_q;
  logic        ring_we;

  logic [HW-1:0]   head_q;
  logic [CntW-1:0] count_q;
  logic [HW-1:0]   idx_q;
  logic [CntW-1:0] i_q;
  logic [HW-1:0]   head_nx;
  logic [CntW-1:0] cnt_nx;
  logic [CntW:0]   old_sum;
  logic [HW-1:0]   oldest;
  logic [HW-1:0]   idx_nx;

  // Per-sample products and running sums
  logic [31:0] t0_q;
  logic [31:0] t_c;
  logic [31:0] t_q;
  logic [15:0] y_q;
  logic [63:0] tt_q;
  logic [47:0] ty_q;
  logic [31:0] yy_q;
  logic [tlte_pkg::StW-1:0]  st_q;
  logic [tlte_pkg::SyW-1:0]  sy_q;
  logic [tlte_pkg::StyW-1:0] sty_q;
  logic [tlte_pkg::SyyW-1:0] syy_q;
  logic [tlte_pkg::SttW-1:0] stt_q;

  // Fit terms
  logic [tlte_pkg::PW-1:0]  p1_q;
  logic [tlte_pkg::AW-1:0]  a_q;
  logic [tlte_pkg::BW-1:0]  b_q;
  logic [tlte_pkg::CW-1:0]  c_q;
  logic [tlte_pkg::B2W-1:0] b2_q;
  logic [tlte_pkg::B2W-1:0] resid_q;
  logic                     neg_q;
  logic                     sig_q;
  logic [tlte_pkg::PW-1:0]  prod;
  logic [tlte_pkg::AW-1:0]  a_c;
  logic                     sig_c;

  // Flow division
  logic [tlte_pkg::NumW-1:0] rem_q;
  logic [tlte_pkg::DenW-1:0] dsh_q;
  logic [4:0]                k_q;

  // Result and output registers
  tlte_pkg::status_e res_status_q;
  tlte_pkg::trend_e  res_trend_q;
  logic [31:0]       res_flow_q;
  logic [15:0]       cur_level_q;
  logic              out_valid_q;
  logic              out_load;
  tlte_pkg::status_e out_status_q;
  tlte_pkg::trend_e  out_trend_q;
  logic [15:0]       out_level_q;
  logic [31:0]       out_flow_q;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign ring_we = q_pop_o && (cmd_i.kind == tlte_pkg::ST_OK);

  // Post the result once the output register is free or being emptied
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Ring pointers after a push
  assign head_nx = (32'(head_q) == WINDOW_SAMPLES - 1) ? '0 : head_q + 1'b1;
  assign cnt_nx  = (32'(count_q) == WINDOW_SAMPLES) ? count_q : count_q + 1'b1;
  assign old_sum = (CntW+1)'(head_nx) + WinW - (CntW+1)'(cnt_nx);
  assign oldest  = (old_sum >= WinW) ? HW'(old_sum - WinW) : HW'(old_sum);
  assign idx_nx  = (32'(idx_q) == WINDOW_SAMPLES - 1) ? '0 : idx_q + 1'b1;

  assign t_c  = (i_q == '0) ? '0 : rd_time_q - t0_q;
  assign prod = mul_rsp_i.product;
  assign a_c  = tlte_pkg::AW'(p1_q - prod);
  assign sig_c = sig_q && !(p1_q < prod);

  // Ring write and registered read
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_time[head_q]  <= cmd_i.now;
      ring_level[head_q] <= cmd_i.level;
    end
    rd_time_q  <= ring_time[idx_q];
    rd_level_q <= ring_level[idx_q];
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_req_o.start  = (state_q == S_MSTART);
    mul_req_o.mcand  = '0;
    mul_req_o.mplier = '0;
    unique case (op_q)
      tlte_pkg::OP_NSTT: begin
        mul_req_o.mcand  = tlte_pkg::PW'(stt_q);
        mul_req_o.mplier = tlte_pkg::MW'(count_q);
      end
      tlte_pkg::OP_STST: begin
        mul_req_o.mcand  = tlte_pkg::PW'(st_q);
        mul_req_o.mplier = tlte_pkg::MW'(st_q);
      end
      tlte_pkg::OP_NSTY: begin
        mul_req_o.mcand  = tlte_pkg::PW'(sty_q);
        mul_req_o.mplier = tlte_pkg::MW'(count_q);
      end
      tlte_pkg::OP_STSY: begin
        mul_req_o.mcand  = tlte_pkg::PW'(sy_q);
        mul_req_o.mplier = tlte_pkg::MW'(st_q);
      end
      tlte_pkg::OP_NSYY: begin
        mul_req_o.mcand  = tlte_pkg::PW'(syy_q);
        mul_req_o.mplier = tlte_pkg::MW'(count_q);
      end
      tlte_pkg::OP_SYSY: begin
        mul_req_o.mcand  = tlte_pkg::PW'(sy_q);
        mul_req_o.mplier = tlte_pkg::MW'(sy_q);
      end
      tlte_pkg::OP_FLR_B: begin
        mul_req_o.mcand  = tlte_pkg::PW'(b_q);
        mul_req_o.mplier = tlte_pkg::ScaleUm;
      end
      tlte_pkg::OP_FLR_A: begin
        mul_req_o.mcand  = tlte_pkg::PW'(a_q);
        mul_req_o.mplier = tlte_pkg::MW'(cfg_i.min_slope);
      end
      tlte_pkg::OP_BB: begin
        mul_req_o.mcand  = tlte_pkg::PW'(b_q);
        mul_req_o.mplier = b_q;
      end
      tlte_pkg::OP_AC: begin
        mul_req_o.mcand  = tlte_pkg::PW'(a_q);
        mul_req_o.mplier = tlte_pkg::MW'(c_q);
      end
      tlte_pkg::OP_LHS: begin
        mul_req_o.mcand  = tlte_pkg::PW'(b2_q);
        mul_req_o.mplier = tlte_pkg::MW'(count_q - 2'd2) << 16;
      end
      tlte_pkg::OP_RHS: begin
        mul_req_o.mcand  = tlte_pkg::PW'(resid_q);
        mul_req_o.mplier = TStat2;
      end
      tlte_pkg::OP_FLOW: begin
        mul_req_o.mcand  = tlte_pkg::PW'(b_q);
        mul_req_o.mplier = tlte_pkg::MW'(cfg_i.area) * tlte_pkg::MW'(tlte_pkg::FlowMul);
      end
      default: begin
        mul_req_o.mcand  = '0;
        mul_req_o.mplier = '0;
      end
    endcase
  end

  // Sequencer: take a request, walk the window, run the fit, post the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= tlte_pkg::OP_NSTT;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      i_q          <= '0;
      cur_level_q  <= '0;
      res_status_q <= tlte_pkg::ST_WARMING;
      res_trend_q  <= tlte_pkg::TR_UNKNOWN;
      res_flow_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= tlte_pkg::ST_WARMING;
      out_trend_q  <= tlte_pkg::TR_UNKNOWN;
      out_level_q  <= '0;
      out_flow_q   <= '0;
      t0_q <= '0; t_q <= '0; y_q <= '0;
      tt_q <= '0; ty_q <= '0; yy_q <= '0;
      st_q <= '0; sy_q <= '0; sty_q <= '0; syy_q <= '0; stt_q <= '0;
      p1_q <= '0; a_q <= '0; b_q <= '0; c_q <= '0;
      b2_q <= '0; resid_q <= '0; neg_q <= 1'b0; sig_q <= 1'b0;
      rem_q <= '0; dsh_q <= '0; k_q <= '0;
    end else begin
      // Set on a new result, drop once the receiver takes it
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (cmd_i.kind == tlte_pkg::ST_OK) begin
              head_q       <= head_nx;
              count_q      <= cnt_nx;
              cur_level_q  <= cmd_i.level;
              res_status_q <= tlte_pkg::ST_OK;
              idx_q        <= oldest;
              i_q          <= '0;
              st_q <= '0; sy_q <= '0; sty_q <= '0; syy_q <= '0; stt_q <= '0;
              if (32'(cnt_nx) < MinN) begin
                res_trend_q <= tlte_pkg::TR_UNKNOWN;
                res_flow_q  <= '0;
                state_q     <= S_DONE;
              end else begin
                state_q <= S_RD;
              end
            end else begin
              head_q       <= '0;
              count_q      <= '0;
              res_status_q <= cmd_i.kind;
              res_trend_q  <= tlte_pkg::TR_UNKNOWN;
              res_flow_q   <= '0;
              state_q      <= S_DONE;
            end
          end
        end
        S_RD: begin
          state_q <= S_MAC;
        end
        S_MAC: begin
          if (i_q == '0) begin
            t0_q <= rd_time_q;
          end
          t_q     <= t_c;
          y_q     <= rd_level_q;
          tt_q    <= 64'(t_c) * 64'(t_c);
          ty_q    <= 48'(t_c) * 48'(rd_level_q);
          yy_q    <= 32'(rd_level_q) * 32'(rd_level_q);
          state_q <= S_ADD;
        end
        S_ADD: begin
          st_q  <= st_q + tlte_pkg::StW'(t_q);
          sy_q  <= sy_q + tlte_pkg::SyW'(y_q);
          sty_q <= sty_q + tlte_pkg::StyW'(ty_q);
          syy_q <= syy_q + tlte_pkg::SyyW'(yy_q);
          stt_q <= stt_q + tlte_pkg::SttW'(tt_q);
          if ((i_q + 1'b1) == count_q) begin
            op_q    <= tlte_pkg::OP_NSTT;
            state_q <= S_MSTART;
          end else begin
            i_q     <= i_q + 1'b1;
            idx_q   <= idx_nx;
            state_q <= S_RD;
          end
        end
        S_MSTART: begin
          state_q <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_rsp_i.done) begin
            state_q <= S_MSTART;
            unique case (op_q)
              tlte_pkg::OP_NSTT: begin
                p1_q <= prod;
                op_q <= tlte_pkg::OP_STST;
              end
              tlte_pkg::OP_STST: begin
                a_q <= a_c;
                if (a_c == '0) begin
                  res_trend_q <= tlte_pkg::TR_UNKNOWN;
                  res_flow_q  <= '0;
                  state_q     <= S_DONE;
                end else begin
                  op_q <= tlte_pkg::OP_NSTY;
                end
              end
              tlte_pkg::OP_NSTY: begin
                p1_q <= prod;
                op_q <= tlte_pkg::OP_STSY;
              end
              tlte_pkg::OP_STSY: begin
                neg_q <= (p1_q < prod);
                b_q   <= (p1_q < prod) ? tlte_pkg::BW'(prod - p1_q)
                                       : tlte_pkg::BW'(p1_q - prod);
                op_q  <= tlte_pkg::OP_NSYY;
              end
              tlte_pkg::OP_NSYY: begin
                p1_q <= prod;
                op_q <= tlte_pkg::OP_SYSY;
              end
              tlte_pkg::OP_SYSY: begin
                c_q  <= (p1_q >= prod) ? tlte_pkg::CW'(p1_q - prod) : '0;
                op_q <= tlte_pkg::OP_FLR_B;
              end
              tlte_pkg::OP_FLR_B: begin
                p1_q <= prod;
                op_q <= tlte_pkg::OP_FLR_A;
              end
              tlte_pkg::OP_FLR_A: begin
                sig_q <= (p1_q >= prod);
                op_q  <= tlte_pkg::OP_BB;
              end
              tlte_pkg::OP_BB: begin
                b2_q <= tlte_pkg::B2W'(prod);
                op_q <= tlte_pkg::OP_AC;
              end
              tlte_pkg::OP_AC: begin
                resid_q <= (prod > tlte_pkg::PW'(b2_q))
                         ? tlte_pkg::B2W'(prod - tlte_pkg::PW'(b2_q)) : '0;
                op_q    <= tlte_pkg::OP_LHS;
              end
              tlte_pkg::OP_LHS: begin
                p1_q <= prod;
                op_q <= tlte_pkg::OP_RHS;
              end
              tlte_pkg::OP_RHS: begin
                res_flow_q <= '0;
                if (!sig_c) begin
                  res_trend_q <= tlte_pkg::TR_STEADY;
                  state_q     <= S_DONE;
                end else begin
                  res_trend_q <= neg_q ? tlte_pkg::TR_FALLING : tlte_pkg::TR_RISING;
                  if (cfg_i.area == '0) begin
                    state_q <= S_DONE;
                  end else begin
                    op_q <= tlte_pkg::OP_FLOW;
                  end
                end
              end
              tlte_pkg::OP_FLOW: begin
                // Saturate when the quotient needs more than 32 bits
                if (prod >= (tlte_pkg::PW'(a_q) << 32)) begin
                  res_flow_q <= '1;
                  state_q    <= S_DONE;
                end else begin
                  res_flow_q <= '0;
                  rem_q      <= tlte_pkg::NumW'(prod);
                  dsh_q      <= tlte_pkg::DenW'(a_q) << 31;
                  k_q        <= 5'd31;
                  state_q    <= S_DIV;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_DIV: begin
          // One quotient bit a cycle, shifted in from the bottom
          if (tlte_pkg::DenW'(rem_q) >= dsh_q) begin
            rem_q      <= tlte_pkg::NumW'(tlte_pkg::DenW'(rem_q) - dsh_q);
            res_flow_q <= {res_flow_q[30:0], 1'b1};
          end else begin
            res_flow_q <= {res_flow_q[30:0], 1'b0};
          end
          dsh_q <= dsh_q >> 1;
          k_q   <= k_q - 1'b1;
          if (k_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_status_q <= res_status_q;
            out_trend_q  <= res_trend_q;
            out_level_q  <= cur_level_q;
            out_flow_q   <= res_flow_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign trend_o           = out_trend_q;
  assign level_mm_o        = out_level_q;
  assign flow_ml_per_min_o = out_flow_q;

  `TLTE_ASSERT(a_fault_no_trend, out_valid_o && (status_o == tlte_pkg::ST_OPEN || status_o == tlte_pkg::ST_OVER) |-> trend_o == tlte_pkg::TR_UNKNOWN && flow_ml_per_min_o == '0, "fault result carries a trend or flow")
  `TLTE_ASSERT(a_flow_needs_trend, out_valid_o && (trend_o == tlte_pkg::TR_UNKNOWN || trend_o == tlte_pkg::TR_STEADY) |-> flow_ml_per_min_o == '0, "flow reported without a trend")
  `TLTE_ASSERT(a_mul_free, mul_req_o.start |-> !mul_rsp_i.busy, "multiplier started while busy")
  `TLTE_ASSERT_ALWAYS(a_count_bound, !rst_ni || 32'(count_q) <= WINDOW_SAMPLES, "sample count beyond window")

endmodule

// ===== src/tank_level_trend_estimator.sv =====
// Tank level trend estimator.
// Input channel (in_valid_i/in_ready_o) carries now_ms_i and raw_i; output
// channel (out_valid_o/out_ready_i) carries status, trend, level and flow.
// A request that arrives before sample_interval_ms has passed gives no result.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must write it only while idle, as the block does not enforce this.
// A fault gives its result without a fit. A healthy sample with enough
// history walks the n-sample window (read, multiply, add per sample), then
// makes up to twelve passes through the shared shift-add multiplier and,
// for the flow, a thirteenth pass and a divide giving 32 quotient bits.
// A new request is taken from the queue only once the result is posted.
// A two-entry request queue lets the input side run ahead of the fit.
// Reset clears the window, status reads warming up, level and flow zero;
// the ring needs no clearing pass. A stalled receiver holds the result in
// the output register; the next fit runs and waits behind it.
module tank_level_trend_estimator #(
  parameter int unsigned WINDOW_SAMPLES    = 16,
  parameter int unsigned MIN_TREND_SAMPLES = 3,
  parameter int unsigned ADC_BITS          = 12,
  parameter int unsigned T_STAT_Q8         = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [31:0]                now_ms_i,
  input  logic [11:0]                raw_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [1:0]                 trend_o,
  output logic [15:0]                level_mm_o,
  output logic [31:0]                flow_ml_per_min_o,
  input  logic                       cfg_we_i,
  input  logic [tlte_pkg::CfgAw-1:0] cfg_idx_i,
  input  logic [tlte_pkg::CfgDw-1:0] cfg_wdata_i
);

  tlte_pkg::cfg_t     cfg_q;
  tlte_pkg::cmd_t     push_cmd;
  tlte_pkg::cmd_t     pop_cmd;
  tlte_pkg::mul_req_t mul_req;
  tlte_pkg::mul_rsp_t mul_rsp;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval  <= 16'd1000;
      cfg_q.min_raw   <= 12'd410;
      cfg_q.max_raw   <= 12'd4095;
      cfg_q.zero_raw  <= 12'd410;
      cfg_q.gain      <= 24'd88920;
      cfg_q.range_mm  <= 16'd5000;
      cfg_q.min_slope <= '0;
      cfg_q.area      <= '0;
    end else if (cfg_we_i) begin
      unique case (tlte_pkg::cfg_idx_e'(cfg_idx_i))
        tlte_pkg::CFG_INTERVAL:  cfg_q.interval  <= cfg_wdata_i[15:0];
        tlte_pkg::CFG_MIN_RAW:   cfg_q.min_raw   <= cfg_wdata_i[11:0];
        tlte_pkg::CFG_MAX_RAW:   cfg_q.max_raw   <= cfg_wdata_i[11:0];
        tlte_pkg::CFG_ZERO_RAW:  cfg_q.zero_raw  <= cfg_wdata_i[11:0];
        tlte_pkg::CFG_GAIN:      cfg_q.gain      <= cfg_wdata_i[23:0];
        tlte_pkg::CFG_RANGE:     cfg_q.range_mm  <= cfg_wdata_i[15:0];
        tlte_pkg::CFG_MIN_SLOPE: cfg_q.min_slope <= cfg_wdata_i[19:0];
        tlte_pkg::CFG_AREA:      cfg_q.area      <= cfg_wdata_i[26:0];
        default:                 cfg_q           <= cfg_q;
      endcase
    end
  end

  tlte_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .now_ms_i   (now_ms_i),
    .raw_i      (raw_i),
    .full_i     (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tlte_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  tlte_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  tlte_back #(
    .WINDOW_SAMPLES    (WINDOW_SAMPLES),
    .MIN_TREND_SAMPLES (MIN_TREND_SAMPLES),
    .T_STAT_Q8         (T_STAT_Q8)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid),
    .cmd_i             (pop_cmd),
    .q_pop_o           (pop),
    .mul_req_o         (mul_req),
    .mul_rsp_i         (mul_rsp),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .trend_o           (trend_o),
    .level_mm_o        (level_mm_o),
    .flow_ml_per_min_o (flow_ml_per_min_o)
  );

endmodule
